FILE: sv/at2p_pkg.sv
// ----------------------------------------------------------------------------
// at2p_pkg
// Shared types and constants for the atan2 polynomial core.
// ----------------------------------------------------------------------------
package at2p_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned RATIO_FRAC_DEF  = 16;

  // Polynomial datapath: Q.16, signed, wide enough for pi in Q.16
  localparam int unsigned POLY_FRAC = 16;
  localparam int unsigned POLY_W    = 20;
  localparam int unsigned ANGLE_W   = 16;

  // A&S 4.4.49 coefficients, rounded at 2^-16
  localparam logic signed [POLY_W-1:0] NEG_COEF_A  = -20'sd3047;
  localparam logic signed [POLY_W-1:0] COEF_B      = 20'sd10441;
  localparam logic signed [POLY_W-1:0] COEF_C      = 20'sd21471;
  localparam logic signed [POLY_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [POLY_W-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [POLY_W-1:0] ROUND_HALF  = 20'sd4;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd25736;

  // Quadrant flags carried alongside the ratio
  typedef struct packed {
    logic zero;    // both coordinates zero
    logic swap;    // |y| > |x|
    logic x_neg;
    logic y_neg;
  } at2p_quad_t;

endpackage

FILE: sv/at2p_div_step.sv
// ----------------------------------------------------------------------------
// at2p_div_step
// One restoring-division step as a pipeline stage: one quotient bit per item.
// ----------------------------------------------------------------------------
module at2p_div_step #(
  parameter int unsigned COORD_WIDTH     = at2p_pkg::COORD_WIDTH_DEF,
  parameter int unsigned RATIO_FRAC_BITS = at2p_pkg::RATIO_FRAC_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [COORD_WIDTH-1:0]     rem_i,
  input  logic [COORD_WIDTH-1:0]     hi_i,
  input  logic [RATIO_FRAC_BITS:0]   quo_i,
  input  at2p_pkg::at2p_quad_t       quad_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [COORD_WIDTH-1:0]     rem_o,
  output logic [COORD_WIDTH-1:0]     hi_o,
  output logic [RATIO_FRAC_BITS:0]   quo_o,
  output at2p_pkg::at2p_quad_t       quad_o
);
  import at2p_pkg::*;

  logic                       valid_q;
  logic [COORD_WIDTH:0]       trial;
  logic [COORD_WIDTH:0]       diff;
  logic                       ge;
  logic [COORD_WIDTH-1:0]     rem_d, rem_q;
  logic [COORD_WIDTH-1:0]     hi_q;
  logic [RATIO_FRAC_BITS:0]   quo_d, quo_q;
  at2p_quad_t                 quad_q;

  // rem < hi on entry, so the doubled remainder fits in one extra bit
  always_comb begin
    trial = {rem_i, 1'b0};
    diff  = trial - {1'b0, hi_i};
    ge    = (trial >= {1'b0, hi_i});
    rem_d = ge ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
    quo_d = {quo_i[RATIO_FRAC_BITS-1:0], ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      hi_q   <= hi_i;
      quo_q  <= quo_d;
      quad_q <= quad_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign hi_o    = hi_q;
  assign quo_o   = quo_q;
  assign quad_o  = quad_q;

endmodule

FILE: sv/at2p_poly.sv
// ----------------------------------------------------------------------------
// at2p_poly
// Five-stage pipeline evaluating atan(a) ~= a + a^3*(-C + a^2*(B - A*a^2)),
// one multiplier per stage, products floored to Q.16.
// ----------------------------------------------------------------------------
module at2p_poly #(
  parameter int unsigned RATIO_FRAC_BITS = at2p_pkg::RATIO_FRAC_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [RATIO_FRAC_BITS:0]             ratio_i,
  input  at2p_pkg::at2p_quad_t                 quad_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [at2p_pkg::POLY_W-1:0]   mag_o,
  output at2p_pkg::at2p_quad_t                 quad_o
);
  import at2p_pkg::*;

  localparam int unsigned NST = 5;

  function automatic logic signed [POLY_W-1:0] mul_q16(
    input logic signed [POLY_W-1:0] x,
    input logic signed [POLY_W-1:0] y
  );
    logic signed [2*POLY_W-1:0] pr;
    pr = x * y;
    return POLY_W'(pr >>> POLY_FRAC);
  endfunction

  logic [POLY_FRAC:0]        a_u;
  logic signed [POLY_W-1:0]  a_c;

  // Ratio to Q.16: drop low bits or pad with zeros
  generate
    if (RATIO_FRAC_BITS >= POLY_FRAC) begin : g_trunc
      assign a_u = ratio_i[RATIO_FRAC_BITS -: (POLY_FRAC + 1)];
    end else begin : g_pad
      assign a_u = {ratio_i, {(POLY_FRAC - RATIO_FRAC_BITS){1'b0}}};
    end
  endgenerate

  assign a_c = $signed({{(POLY_W - POLY_FRAC - 1){1'b0}}, a_u});

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  at2p_quad_t s1_quad_q, s2_quad_q, s3_quad_q, s4_quad_q, s5_quad_q;
  logic signed [POLY_W-1:0] s1_a_q, s1_sq_q;
  logic signed [POLY_W-1:0] s2_a_q, s2_sq_q, s2_p_q;
  logic signed [POLY_W-1:0] s3_a_q, s3_sq_q, s3_p_q;
  logic signed [POLY_W-1:0] s4_a_q, s4_p_q;
  logic signed [POLY_W-1:0] s5_mag_q;

  logic signed [POLY_W-1:0] s1_sq_d, s2_p_d, s3_p_d, s4_p_d, s5_mag_d;

  always_comb begin
    s1_sq_d  = mul_q16(a_c, a_c);
    s2_p_d   = mul_q16(NEG_COEF_A, s1_sq_q) + COEF_B;
    s3_p_d   = mul_q16(s2_p_q, s2_sq_q) - COEF_C;
    s4_p_d   = mul_q16(s3_p_q, s3_sq_q);
    s5_mag_d = mul_q16(s4_p_q, s4_a_q) + s4_a_q;
  end

  // A stage loads when empty or when its content moves on
  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      s1_quad_q <= quad_i;
      s1_a_q    <= a_c;
      s1_sq_q   <= s1_sq_d;
    end
    if (rdy[1] && v_q[0]) begin
      s2_quad_q <= s1_quad_q;
      s2_a_q    <= s1_a_q;
      s2_sq_q   <= s1_sq_q;
      s2_p_q    <= s2_p_d;
    end
    if (rdy[2] && v_q[1]) begin
      s3_quad_q <= s2_quad_q;
      s3_a_q    <= s2_a_q;
      s3_sq_q   <= s2_sq_q;
      s3_p_q    <= s3_p_d;
    end
    if (rdy[3] && v_q[2]) begin
      s4_quad_q <= s3_quad_q;
      s4_a_q    <= s3_a_q;
      s4_p_q    <= s4_p_d;
    end
    if (rdy[4] && v_q[3]) begin
      s5_quad_q <= s4_quad_q;
      s5_mag_q  <= s5_mag_d;
    end
  end

  assign valid_o = v_q[NST-1];
  assign mag_o   = s5_mag_q;
  assign quad_o  = s5_quad_q;

endmodule

FILE: sv/atan2_polynomial_core.sv
// ----------------------------------------------------------------------------
// atan2_polynomial_core
// Angle of (x, y) in signed Q2.13 radians: magnitude sort, pipelined
// restoring divider, polynomial pipeline, quadrant fix-up and rounding.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i, in_ready_o, x_coord_i, y_coord_i | in
//  out     | out_valid_o, out_ready_i, angle_o         | out
//
//  One item per cycle sustained while out_ready_i stays high; the stages are
//  1 magnitude stage, one divider stage per ratio fraction bit,
//  5 multiplier stages and 1 output stage.
//  Each stage has its own valid bit and loads when empty or draining, so
//  bubbles are squeezed out under a stall and nothing is dropped.
//  Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module atan2_polynomial_core #(
  parameter int unsigned COORD_WIDTH     = at2p_pkg::COORD_WIDTH_DEF,
  parameter int unsigned RATIO_FRAC_BITS = at2p_pkg::RATIO_FRAC_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]         x_coord_i,
  input  logic signed [COORD_WIDTH-1:0]         y_coord_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [at2p_pkg::ANGLE_W-1:0]   angle_o
);
  import at2p_pkg::*;

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned R = RATIO_FRAC_BITS;

  // ---------------- magnitude stage ----------------
  logic [W-1:0]  ax, ay, lo, hi;
  logic          q_top;
  at2p_quad_t    quad_c;

  always_comb begin
    ax     = x_coord_i[W-1] ? (~x_coord_i + 1'b1) : x_coord_i;
    ay     = y_coord_i[W-1] ? (~y_coord_i + 1'b1) : y_coord_i;
    quad_c.zero  = (ax == '0) && (ay == '0);
    quad_c.swap  = (ay > ax);
    quad_c.x_neg = x_coord_i[W-1];
    quad_c.y_neg = y_coord_i[W-1];
    lo     = quad_c.swap ? ax : ay;
    hi     = quad_c.swap ? ay : ax;
    // integer quotient bit: set only for equal magnitudes
    q_top  = (lo == hi);
  end

  logic           v_s   [R+1];
  logic           rdy_s [R+1];
  logic [W-1:0]   rem_s [R+1];
  logic [W-1:0]   hi_s  [R+1];
  logic [R:0]     quo_s [R+1];
  at2p_quad_t     quad_s[R+1];

  logic s0_v_q;
  assign in_ready_o = !s0_v_q || rdy_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rem_s[0]  <= q_top ? '0 : lo;
      hi_s[0]   <= hi;
      quo_s[0]  <= (R+1)'(q_top);
      quad_s[0] <= quad_c;
    end
  end

  assign v_s[0] = s0_v_q;

  // ---------------- divider: one fraction bit per stage ----------------
  for (genvar k = 0; k < R; k++) begin : g_div
    at2p_div_step #(
      .COORD_WIDTH    (COORD_WIDTH),
      .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v_s[k]),
      .ready_o(rdy_s[k]),
      .rem_i  (rem_s[k]),
      .hi_i   (hi_s[k]),
      .quo_i  (quo_s[k]),
      .quad_i (quad_s[k]),
      .valid_o(v_s[k+1]),
      .ready_i(rdy_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .hi_o   (hi_s[k+1]),
      .quo_o  (quo_s[k+1]),
      .quad_o (quad_s[k+1])
    );
  end

  // ---------------- polynomial ----------------
  logic                      poly_v;
  logic                      poly_rdy;
  logic signed [POLY_W-1:0]  poly_mag;
  at2p_quad_t                poly_quad;

  at2p_poly #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v_s[R]),
    .ready_o(rdy_s[R]),
    .ratio_i(quo_s[R]),
    .quad_i (quad_s[R]),
    .valid_o(poly_v),
    .ready_i(poly_rdy),
    .mag_o  (poly_mag),
    .quad_o (poly_quad)
  );

  // ---------------- quadrant fix-up and rounding ----------------
  logic signed [POLY_W-1:0]  m1, m2, mcl, msum;
  logic [ANGLE_W-1:0]        rnd;
  logic signed [ANGLE_W-1:0] angle_d, angle_q;
  logic                      out_v_q;

  always_comb begin
    m1      = poly_quad.swap  ? (HALF_PI_Q16 - poly_mag) : poly_mag;
    m2      = poly_quad.x_neg ? (PI_Q16 - m1) : m1;
    mcl     = m2[POLY_W-1] ? '0 : m2;
    msum    = mcl + ROUND_HALF;
    rnd     = msum[ANGLE_W+2:3];
    if (poly_quad.zero) begin
      angle_d = '0;
    end else if (poly_quad.y_neg) begin
      angle_d = $signed(-rnd);
    end else begin
      angle_d = $signed(rnd);
    end
  end

  assign poly_rdy = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (poly_rdy) begin
      out_v_q <= poly_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poly_rdy && poly_v) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign angle_o     = angle_q;

`ifndef SYNTH
  // quotient never exceeds 1.0; a zero pair divides by zero and is ignored
  a_ratio_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_s[R] && !quad_s[R].zero && quo_s[R][R] |-> quo_s[R][R-1:0] == '0)
    else $error("ratio above 1.0");

  // atan of a ratio in [0,1] lies in [0, pi/2]
  a_poly_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poly_v && !poly_quad.zero |-> poly_mag >= 0 && poly_mag <= HALF_PI_Q16)
    else $error("polynomial magnitude out of range");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_o <= ANGLE_MAX && angle_o >= -ANGLE_MAX)
    else $error("angle beyond pi");

  // a finished item leaving the fix-up stage lands in the output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poly_v && poly_rdy |=> out_valid_o && angle_o == $past(angle_d))
    else $error("output register not loaded");
`endif

endmodule

FILE: verif/atan2_polynomial_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atan2_polynomial_core_tb
// Checks the angle of each (x, y) pair against a bit-exact polynomial atan2
// predictor. A directed table of corner pairs runs first, followed by random
// pairs, with random idle gaps on both handshakes and a long output hold-off
// that makes the pipeline back up.
// ----------------------------------------------------------------------------
module atan2_polynomial_core_tb;

  localparam int unsigned CW           = at2p_pkg::COORD_WIDTH_DEF;
  localparam int unsigned AW           = at2p_pkg::ANGLE_W;
  localparam int          LATENCY      = at2p_pkg::RATIO_FRAC_DEF + 7;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          WATCHDOG_MAX = 2000;
  localparam int          N_DIR        = 25;

  // Polynomial constants in Q.16
  localparam longint K_CUBIC  = 21471;
  localparam longint K_QUINT  = 10441;
  localparam longint K_SEPT   = 3047;
  localparam longint HALF_PI  = 102944;
  localparam longint FULL_PI  = 205887;
  localparam int     Q_FRAC   = 16;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [AW-1:0] angle_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   typed;
    angle_t angle;
  } coord_row_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    angle_t angle;
  } pending_angle_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  coord_t x_coord_i;
  coord_t y_coord_i;
  logic   out_valid_o;
  logic   out_ready_i;
  angle_t angle_o;

  pending_angle_t angle_q[$];
  int             n_fail       = 0;
  int             stall_cycles = 0;
  int             rx_stall_pct = 0;
  bit             hold_req     = 1'b0;

  // Known angles: axes give 0, +-pi/2 or pi exactly
  coord_row_t dir_rows [N_DIR] = '{
    '{16'sd0,      16'sd0,      1'b1, 16'sd0},
    '{16'sd1,      16'sd0,      1'b1, 16'sd0},
    '{16'sd32767,  16'sd0,      1'b1, 16'sd0},
    '{-16'sd1,     16'sd0,      1'b1, 16'sd25736},
    '{-16'sd32768, 16'sd0,      1'b1, 16'sd25736},
    '{16'sd0,      16'sd1,      1'b1, 16'sd12868},
    '{16'sd0,      16'sd32767,  1'b1, 16'sd12868},
    '{16'sd0,      -16'sd1,     1'b1, -16'sd12868},
    '{16'sd0,      -16'sd32768, 1'b1, -16'sd12868},
    '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
    '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0},
    '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0},
    '{-16'sd32767, -16'sd32768, 1'b0, 16'sd0},
    '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
    '{16'sd1,      -16'sd1,     1'b0, 16'sd0},
    '{-16'sd1,     16'sd1,      1'b0, 16'sd0},
    '{16'sd21845,  -16'sd21846, 1'b0, 16'sd0},
    '{-16'sd21846, 16'sd21845,  1'b0, 16'sd0},
    '{16'sd3,      16'sd4,      1'b0, 16'sd0},
    '{-16'sd4,     -16'sd3,     1'b0, 16'sd0},
    '{16'sd12345,  -16'sd23456, 1'b0, 16'sd0},
    '{-16'sd32768, 16'sd1,      1'b0, 16'sd0},
    '{-16'sd32768, -16'sd1,     1'b0, 16'sd0},
    '{16'sd1,      -16'sd32768, 1'b0, 16'sd0}
  };

  atan2_polynomial_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .angle_o     (angle_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic angle_t predict_angle(input coord_t xc, input coord_t yc);
    longint xv, yv, ax, ay, lo, hi, a, a2, p, mag;
    xv = xc;
    yv = yc;
    ax = (xv < 0) ? -xv : xv;
    ay = (yv < 0) ? -yv : yv;
    if (ax == 0 && ay == 0) begin
      return '0;
    end
    lo = (ax > ay) ? ay : ax;
    hi = (ax > ay) ? ax : ay;
    a  = (lo <<< Q_FRAC) / hi;
    // products floor to Q.16; >>> on a signed longint is a floor
    a2  = (a * a) >>> Q_FRAC;
    p   = ((-K_SEPT * a2) >>> Q_FRAC) + K_QUINT;
    p   = ((p * a2) >>> Q_FRAC) - K_CUBIC;
    p   = (p * a2) >>> Q_FRAC;
    p   = (p * a) >>> Q_FRAC;
    mag = p + a;
    if (ay > ax) mag = HALF_PI - mag;
    if (xv < 0)  mag = FULL_PI - mag;
    if (mag < 0) mag = 0;
    mag = (mag + 4) >>> 3;
    if (yv < 0) mag = -mag;
    return mag[AW-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic gen_coords(output coord_t xc, output coord_t yc);
    int     pick;
    coord_t mag;
    coord_t corners [6];
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    pick = $urandom_range(99);
    mag  = coord_t'($urandom());
    if (pick < 50) begin
      xc = coord_t'($urandom());
      yc = coord_t'($urandom());
    end else if (pick < 62) begin
      xc = coord_t'($urandom_range(0, 15)) - 16'sd8;
      yc = coord_t'($urandom_range(0, 15)) - 16'sd8;
    end else if (pick < 72) begin
      // equal magnitudes, ratio of one
      xc = $urandom_range(1) ? mag : -mag;
      yc = $urandom_range(1) ? mag : -mag;
    end else if (pick < 80) begin
      xc = $urandom_range(1) ? mag : '0;
      yc = (xc == 0) ? mag : '0;
    end else if (pick < 90) begin
      xc = corners[$urandom_range(5)];
      yc = corners[$urandom_range(5)];
    end else begin
      xc = mag;
      yc = mag + coord_t'($urandom_range(0, 6)) - 16'sd3;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(input coord_t xc, input coord_t yc, input bit typed,
                           input angle_t ref_angle, input int gap_pct);
    pending_angle_t entry;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i  <= xc;
    y_coord_i  <= yc;
    do @(posedge clk_i); while (!in_ready_o);
    entry.x     = xc;
    entry.y     = yc;
    entry.angle = typed ? ref_angle : predict_angle(xc, yc);
    angle_q.push_back(entry);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count, input int gap_pct);
    coord_t xc, yc;
    repeat (count) begin
      gen_coords(xc, yc);
      send_pair(xc, yc, 1'b0, '0, gap_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (angle_q.size() != 0) @(negedge clk_i);
  endtask

  // output side: random back-pressure and the long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_stall_pct == 0 || $urandom_range(99) >= rx_stall_pct) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (gap_len() - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    pending_angle_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angle_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected angle %0d with nothing pending", angle_o);
      end else begin
        exp_item = angle_q.pop_front();
        if (angle_o !== exp_item.angle) begin
          n_fail++;
          if (n_fail <= 10)
            $display("angle mismatch x=%0d y=%0d: expected %0d, got %0d",
                     exp_item.x, exp_item.y, exp_item.angle, angle_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    x_coord_i  = '0;
    y_coord_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner table back to back, output always ready
    for (int i = 0; i < N_DIR; i++) begin
      send_pair(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].angle, 0);
    end

    rx_stall_pct = 25;
    send_random(300, 20);
    wait_drained();

    // output held off while input keeps offering: pipeline fills, input stalls
    hold_req = 1'b1;
    send_random(80, 0);
    wait_drained();

    rx_stall_pct = 0;
    send_random(300, 0);

    rx_stall_pct = 40;
    send_random(420, 40);
    wait_drained();

    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_fail == 0 && angle_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
